>>> design/bmh_pkg.sv
package bmh_pkg;

  // width and reset value of the keep_count register
  localparam int unsigned CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] KEEP_RESET = 5'd16;

  // operation codes of an input beat
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  // result load request from the sequencer to the output register
  typedef struct packed {
    logic load;
    logic last;
    logic empty;
  } emit_t;

endpackage

>>> design/bmh_ifs.sv
// input channel: insert or drain request
interface bmh_in_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [KEY_BITS-1:0]   key;
  logic [INDEX_BITS-1:0] index;

  modport source (output valid, output op, output key, output index, input ready);
  modport sink   (input valid, input op, input key, input index, output ready);
endinterface

// result channel: one kept pair per beat
interface bmh_out_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [KEY_BITS-1:0]   out_key;
  logic [INDEX_BITS-1:0] out_index;
  logic                  last;
  logic                  empty_res;

  modport source (output valid, output out_key, output out_index, output last,
                  output empty_res, input ready);
  modport sink   (input valid, input out_key, input out_index, input last,
                  input empty_res, output ready);
endinterface

// configuration channel: keep_count write data
interface bmh_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bmh_pkg::CFG_BITS-1:0]  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/bmh_ram.sv
module bmh_ram #(
  parameter int unsigned W = 48,
  parameter int unsigned D = 17
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] wa,
  input  logic [W-1:0]         wd,
  input  logic [$clog2(D)-1:0] ra,
  input  logic [$clog2(D)-1:0] rb,
  output logic [W-1:0]         qa,
  output logic [W-1:0]         qb
);

  logic [W-1:0] mem [D];

  // one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    qa <= mem[ra];
    qb <= mem[rb];
  end

endmodule

>>> design/bmh_seq.sv
module bmh_seq #(
  parameter int unsigned MAX_KEEP   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned INDEX_BITS = 16,
  localparam int unsigned DW    = KEY_BITS + INDEX_BITS,
  localparam int unsigned DEPTH = MAX_KEEP + 1,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bmh_in_if.sink                        in_ch,
  input  logic [bmh_pkg::CFG_BITS-1:0]  keep,
  input  logic                          out_free,
  output bmh_pkg::emit_t                emit,
  output logic [DW-1:0]                 em_data,
  output logic                          we,
  output logic [AW-1:0]                 wa,
  output logic [DW-1:0]                 wd,
  output logic [AW-1:0]                 ra,
  output logic [AW-1:0]                 rb,
  input  logic [DW-1:0]                 qa,
  input  logic [DW-1:0]                 qb
);

  localparam int unsigned CW  = $clog2(MAX_KEEP + 2);
  localparam int unsigned LW  = (CW > bmh_pkg::CFG_BITS) ? CW : bmh_pkg::CFG_BITS;
  localparam int unsigned CHW = AW + 2;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ROOT_RD  = 4'd1;
  localparam logic [3:0] S_ROOT_CMP = 4'd2;
  localparam logic [3:0] S_UP_RD    = 4'd3;
  localparam logic [3:0] S_UP_CMP   = 4'd4;
  localparam logic [3:0] S_RM_RD    = 4'd5;
  localparam logic [3:0] S_RM_LD    = 4'd6;
  localparam logic [3:0] S_DN_RD    = 4'd7;
  localparam logic [3:0] S_DN_CMP   = 4'd8;
  localparam logic [3:0] S_DR_RD    = 4'd9;
  localparam logic [3:0] S_DR_LD    = 4'd10;
  localparam logic [3:0] S_EMPTY    = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [DW-1:0] mv_r, mv_nxt;
  logic          full_r, full_nxt;
  logic          drain_r, drain_nxt;

  logic [LW-1:0]       kc_w, lim_w, cnt_w;
  logic [KEY_BITS-1:0] mv_key, qa_key, qb_key, ch_key;
  logic [AW-1:0]       parent;
  logic [CHW-1:0]      l_c, r_c;
  logic                pick_l;
  logic [DW-1:0]       ch_data;
  logic [AW-1:0]       ch_addr;

  // active limit: zero acts as one, above MAX_KEEP acts as MAX_KEEP
  always_comb begin
    kc_w  = LW'(keep);
    cnt_w = LW'(cnt_r);
    if (keep == '0) begin
      lim_w = LW'(1);
    end else if (kc_w > LW'(MAX_KEEP)) begin
      lim_w = LW'(MAX_KEEP);
    end else begin
      lim_w = kc_w;
    end
  end

  // key fields and heap neighbors of the current position
  assign mv_key = mv_r[DW-1 -: KEY_BITS];
  assign qa_key = qa[DW-1 -: KEY_BITS];
  assign qb_key = qb[DW-1 -: KEY_BITS];
  assign parent = AW'((pos_r - AW'(1)) >> 1);
  assign l_c    = CHW'({pos_r, 1'b1});
  assign r_c    = CHW'({pos_r, 1'b0}) + CHW'(2);

  // child pick: left when it is the last entry or strictly larger than the right
  assign pick_l  = (l_c == (CHW'(cnt_r) - CHW'(1))) || (qa_key > qb_key);
  assign ch_data = pick_l ? qa : qb;
  assign ch_key  = ch_data[DW-1 -: KEY_BITS];
  assign ch_addr = pick_l ? AW'(l_c) : AW'(r_c);

  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    mv_nxt    = mv_r;
    full_nxt  = full_r;
    drain_nxt = drain_r;
    we        = 1'b0;
    wa        = pos_r;
    wd        = mv_r;
    ra        = '0;
    rb        = '0;
    emit      = '0;
    em_data   = qa;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.op == bmh_pkg::OP_INSERT) begin
            mv_nxt    = {in_ch.key, in_ch.index};
            drain_nxt = 1'b0;
            if (cnt_w < lim_w) begin
              pos_nxt   = AW'(cnt_r);
              full_nxt  = 1'b0;
              state_nxt = S_UP_RD;
            end else begin
              state_nxt = S_ROOT_RD;
            end
          end else begin
            drain_nxt = 1'b1;
            state_nxt = (cnt_r == '0) ? S_EMPTY : S_DR_RD;
          end
        end
      end
      S_ROOT_RD: begin
        ra        = '0;
        state_nxt = S_ROOT_CMP;
      end
      S_ROOT_CMP: begin
        if (mv_key < qa_key) begin
          pos_nxt   = AW'(cnt_r);
          full_nxt  = 1'b1;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = full_r ? S_RM_RD : S_IDLE;
        end else begin
          ra        = parent;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (qa_key < mv_key) begin
          wd        = qa;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = full_r ? S_RM_RD : S_IDLE;
        end
      end
      S_RM_RD: begin
        ra        = AW'(cnt_r - CW'(1));
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = S_RM_LD;
      end
      S_RM_LD: begin
        mv_nxt  = qa;
        pos_nxt = '0;
        if (cnt_r == '0) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_DN_RD;
        end
      end
      S_DN_RD: begin
        if (CW'(pos_r) < (cnt_r >> 1)) begin
          ra        = AW'(l_c);
          rb        = AW'(r_c);
          state_nxt = S_DN_CMP;
        end else begin
          we        = 1'b1;
          state_nxt = drain_r ? S_DR_RD : S_IDLE;
        end
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (ch_key > mv_key) begin
          wd        = ch_data;
          pos_nxt   = ch_addr;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = drain_r ? S_DR_RD : S_IDLE;
        end
      end
      S_DR_RD: begin
        if (out_free) begin
          ra        = '0;
          state_nxt = S_DR_LD;
        end
      end
      S_DR_LD: begin
        emit.load  = 1'b1;
        emit.last  = (cnt_r == CW'(1));
        emit.empty = 1'b0;
        state_nxt  = S_RM_RD;
      end
      S_EMPTY: begin
        em_data = '0;
        if (out_free) begin
          emit.load  = 1'b1;
          emit.empty = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // removal after a drain beat that emptied the heap ends in idle
  // (finish of sift-down checks drain with count left)

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      full_r  <= 1'b0;
      drain_r <= 1'b0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      full_r  <= full_nxt;
      drain_r <= drain_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // moving pair
  always_ff @(posedge clk) begin
    mv_r <= mv_nxt;
  end

endmodule

>>> design/bounded_max_heap_top_k_top.sv
// Keeper of the keep_count smallest (key, index) pairs in a binary max-heap.
// in_ch carries beats with op insert (key, index) or op drain. An insert
// gives no result. A drain gives one out_ch beat per kept pair, largest key
// first, last set on the final one, and leaves the heap empty; a drain of an
// empty heap gives a single beat with empty_res set and all else zero.
// cfg_ch writes keep_count (k); write it only while the block is idle.
// One beat is worked at a time; in_ch.ready is high only when idle. Each heap
// level is a registered memory read, then a compare and write back, on a
// store of MAX_KEEP+1 entries with two read ports and one write port.
// Insert into a heap with room: sift-up only.
// Insert into a full heap: root read and compare (a key not below the root
// is dropped), sift-up, then root removal and sift-down.
// Drain: per emitted pair a root read to the output, removal and sift-down.
// Results sit in an output register; a stalled receiver holds the beat and
// the drain waits for the register to free before reading the next root.
// Reset (rst_n low at a clock edge) empties the heap and sets keep_count to
// 16; the store itself needs no clearing pass.
module bounded_max_heap_top_k_top #(
  parameter int unsigned MAX_KEEP   = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  bmh_in_if.sink     in_ch,
  bmh_out_if.source  out_ch,
  bmh_cfg_if.sink    cfg_ch
);

  localparam int unsigned DW    = KEY_BITS + INDEX_BITS;
  localparam int unsigned DEPTH = MAX_KEEP + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [bmh_pkg::CFG_BITS-1:0] keep_r;
  logic                         out_valid_r;
  logic [KEY_BITS-1:0]          out_key_r;
  logic [INDEX_BITS-1:0]        out_index_r;
  logic                         out_last_r;
  logic                         out_empty_r;
  logic                         out_free;
  bmh_pkg::emit_t               emit;
  logic [DW-1:0]                em_data;
  logic                         we;
  logic [AW-1:0]                wa, ra, rb;
  logic [DW-1:0]                wd, qa, qb;

  // configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= bmh_pkg::KEEP_RESET;
    end else if (cfg_ch.valid) begin
      keep_r <= cfg_ch.data;
    end
  end

  // heap store
  bmh_ram #(
    .W (DW),
    .D (DEPTH)
  ) u_ram (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .ra  (ra),
    .rb  (rb),
    .qa  (qa),
    .qb  (qb)
  );

  // heap sequencer
  bmh_seq #(
    .MAX_KEEP   (MAX_KEEP),
    .KEY_BITS   (KEY_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .keep     (keep_r),
    .out_free (out_free),
    .emit     (emit),
    .em_data  (em_data),
    .we       (we),
    .wa       (wa),
    .wd       (wd),
    .ra       (ra),
    .rb       (rb),
    .qa       (qa),
    .qb       (qb)
  );

  // output register
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_key_r   <= em_data[DW-1 -: KEY_BITS];
      out_index_r <= em_data[INDEX_BITS-1:0];
      out_last_r  <= emit.last;
      out_empty_r <= emit.empty;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_key   = out_key_r;
  assign out_ch.out_index = out_index_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.empty_res = out_empty_r;

endmodule
